@@ hw/rtl/delimited_record_extractor_top_defines.svh @@
// Assertion helpers shared by the record extractor RTL.
`ifndef DELIMITED_RECORD_EXTRACTOR_TOP_DEFINES_SVH
`define DELIMITED_RECORD_EXTRACTOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DRE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/dre_pkg.sv @@
package dre_pkg;

	localparam int unsigned CNT_W     = 16;
	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

	typedef logic [2:0] status_t;
	localparam status_t ST_CHAR      = 3'd0;
	localparam status_t ST_OK        = 3'd1;
	localparam status_t ST_OVERFLOW  = 3'd2;
	localparam status_t ST_TIMEOUT   = 3'd3;
	localparam status_t ST_NEED_MORE = 3'd4;
	localparam status_t ST_PARTIAL   = 3'd5;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_DELIMITER = 2'd0;
	localparam cfg_idx_t CFG_CAPACITY  = 2'd1;
	localparam cfg_idx_t CFG_SCAN      = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int unsigned SLOT_OVF  = 0;
	localparam int unsigned SLOT_CHAR = 1;
	localparam int unsigned SLOT_END  = 2;

	// Up to three results of one item: overflow end, kept char, closing end.
	typedef struct packed {
		logic [2:0]       slot_v;
		logic [7:0]       ch;
		logic [CNT_W-1:0] ovf_len;
		status_t          end_status;
		logic [CNT_W-1:0] end_len;
	} bundle_t;

	typedef struct packed {
		logic [CNT_W-1:0] kept;
		logic [CNT_W-1:0] scanned;
	} counts_t;

	typedef struct packed {
		logic [7:0]       delimiter;
		logic [CNT_W-1:0] capacity;
		logic [CNT_W-1:0] scan_limit;
	} cfg_t;

endpackage

@@ hw/rtl/dre_if.sv @@
interface dre_item_if;
	import dre_pkg::*;

	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface dre_result_if;
	import dre_pkg::*;

	logic             valid;
	logic             ready;
	logic [7:0]       out_byte;
	status_t          status;
	logic [CNT_W-1:0] record_length;
	logic             last;

	modport source (output valid, output out_byte, output status, output record_length,
		output last, input ready);
	modport sink (input valid, input out_byte, input status, input record_length,
		input last, output ready);
endinterface

@@ hw/rtl/dre_step.sv @@
module dre_step (
	input  logic              func,
	input  logic [7:0]        data_byte,
	input  dre_pkg::counts_t  cnt,
	input  dre_pkg::cfg_t     cfg,
	output dre_pkg::bundle_t  bundle,
	output dre_pkg::counts_t  cnt_next
);
	import dre_pkg::*;

	logic [CNT_W-1:0] limit;
	logic             is_delim;
	logic             printable;
	logic             ovf;
	logic [CNT_W-1:0] k0;
	logic [CNT_W-1:0] sc0;
	logic [CNT_W-1:0] sc1;
	logic [CNT_W-1:0] k1;
	logic             keep;
	logic             tmo;

	assign limit     = (cfg.scan_limit == '0) ? CNT_W'(1) : cfg.scan_limit;
	assign is_delim  = (data_byte == cfg.delimiter);
	assign printable = ((data_byte >= CH_SPACE) && (data_byte <= CH_TILDE)) ||
		(data_byte == CH_TAB) || (data_byte == CH_CR);

	// A full record closes before the byte is looked at again as a fresh one.
	assign ovf  = (cnt.kept >= cfg.capacity);
	assign k0   = ovf ? '0 : cnt.kept;
	assign sc0  = ovf ? '0 : cnt.scanned;
	assign sc1  = (sc0 == COUNT_MAX) ? sc0 : sc0 + CNT_W'(1);
	assign keep = printable && (k0 < cfg.capacity);
	assign k1   = (keep && (k0 != COUNT_MAX)) ? k0 + CNT_W'(1) : k0;
	assign tmo  = (sc1 >= limit);

	always_comb begin
		bundle          = '0;
		bundle.ch       = data_byte;
		bundle.ovf_len  = cnt.kept;
		bundle.end_len  = cnt.kept;
		cnt_next        = '0;
		priority if (func) begin
			bundle.slot_v[SLOT_END] = 1'b1;
			bundle.end_status = (cnt.kept == '0) ? ST_NEED_MORE : ST_PARTIAL;
		end else if (is_delim) begin
			bundle.slot_v[SLOT_END] = 1'b1;
			bundle.end_status = ST_OK;
		end else begin
			bundle.slot_v[SLOT_OVF]  = ovf;
			bundle.slot_v[SLOT_CHAR] = keep;
			bundle.slot_v[SLOT_END]  = tmo;
			bundle.end_status        = ST_TIMEOUT;
			bundle.end_len           = k1;
			if (!tmo) begin
				cnt_next.kept    = k1;
				cnt_next.scanned = sc1;
			end
		end
	end
endmodule

@@ hw/rtl/delimited_record_extractor_top.sv @@
// Delimited record extractor. Each item is a data byte or an end-of-input mark;
// each yields zero to three results (overflow end, kept char, closing end). An
// item is held in the input register and its results then leave the result
// register one per cycle while the receiver is ready; items that give at most
// one result thus stream at one per cycle. An item with several results holds
// the result register until all have left. Registers may be written only
// while no item is in flight and take effect from the next item.
module delimited_record_extractor_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  dre_pkg::cfg_idx_t        cfg_index,
	input  logic [dre_pkg::CNT_W-1:0] cfg_wdata,
	dre_item_if.sink                 item,
	dre_result_if.source             result
);
	import dre_pkg::*;

	`include "delimited_record_extractor_top_defines.svh"

	cfg_t       cfg_q;
	counts_t    cnt_q;

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;

	logic [2:0]       slot_v_s2;
	logic [7:0]       ch_s2;
	logic [CNT_W-1:0] ovf_len_s2;
	status_t          end_status_s2;
	logic [CNT_W-1:0] end_len_s2;

	bundle_t    step_bundle;
	counts_t    step_cnt;
	logic       fire_out;
	logic [2:0] lowest;
	logic [2:0] remain;
	logic       adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter  <= 8'd10;
			cfg_q.capacity   <= CNT_W'(16);
			cfg_q.scan_limit <= CNT_W'(100);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELIMITER: cfg_q.delimiter  <= cfg_wdata[7:0];
				CFG_CAPACITY:  cfg_q.capacity   <= cfg_wdata;
				CFG_SCAN:      cfg_q.scan_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

	dre_step u_step (
		.func      (func_s1),
		.data_byte (byte_s1),
		.cnt       (cnt_q),
		.cfg       (cfg_q),
		.bundle    (step_bundle),
		.cnt_next  (step_cnt)
	);

	assign fire_out = result.valid && result.ready;
	assign lowest   = slot_v_s2 & ~(slot_v_s2 - 3'd1);
	assign remain   = fire_out ? (slot_v_s2 & ~lowest) : slot_v_s2;
	assign adv_s1   = valid_s1 && (remain == '0);
	assign item.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			func_s1 <= item.func;
			byte_s1 <= item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			slot_v_s2 <= '0;
		end else if (adv_s1) begin
			cnt_q     <= step_cnt;
			slot_v_s2 <= step_bundle.slot_v;
		end else begin
			slot_v_s2 <= remain;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ch_s2         <= step_bundle.ch;
			ovf_len_s2    <= step_bundle.ovf_len;
			end_status_s2 <= step_bundle.end_status;
			end_len_s2    <= step_bundle.end_len;
		end
	end

	assign result.valid = |slot_v_s2;

	always_comb begin
		result.out_byte      = '0;
		result.status        = end_status_s2;
		result.record_length = end_len_s2;
		result.last          = 1'b1;
		priority if (slot_v_s2[SLOT_OVF]) begin
			result.status        = ST_OVERFLOW;
			result.record_length = ovf_len_s2;
		end else if (slot_v_s2[SLOT_CHAR]) begin
			result.out_byte      = ch_s2;
			result.status        = ST_CHAR;
			result.record_length = '0;
			result.last          = 1'b0;
		end
	end

	`DRE_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv_s1, valid_s1 && $stable(byte_s1) && $stable(func_s1), "stalled input stage lost its item")
	`DRE_ASSERT_NEXT(a_accept_loads, item.valid && item.ready, valid_s1, "accepted transaction missing from input stage")
	`DRE_ASSERT_NEXT(a_last_drains, fire_out && result.last && (slot_v_s2 == lowest) && !adv_s1, slot_v_s2 == '0, "results left after record end")
	`DRE_ASSERT_NEXT(a_end_clears, adv_s1 && step_bundle.slot_v[SLOT_END], cnt_q == '0, "counters not cleared at record end")
endmodule
